/* hw/rtl/vpts_pkg.sv */
// ----------------------------------------------------------------------------
// vpts_pkg
// Types and constants shared by the perspective projection pipeline.
// ----------------------------------------------------------------------------
package vpts_pkg;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;
   localparam int HALF_W        = SCREEN_WIDTH / 2;
   localparam int HALF_H        = SCREEN_HEIGHT / 2;

   localparam int SX_BITS  = 10;
   localparam int SY_BITS  = 9;
   localparam int X_QBITS  = 17;
   localparam int Z_QBITS  = 32;
   localparam int CSR_IDX_BITS = 2;

   // Input register, product, magnitude, divide setup, divide steps, output.
   localparam int PIPE_LATENCY = 4 + Z_QBITS + 1;

   localparam logic [X_QBITS-1:0] ONE_Q16 = X_QBITS'(65536);

   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_X      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_Y      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEPTH_GAIN   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEPTH_OFFSET = 2'd3;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic signed [31:0] vert_w;
   } req_type;

   typedef struct packed {
      logic [SX_BITS-1:0] screen_x;
      logic [SY_BITS-1:0] screen_y;
      logic signed [31:0] depth_ndc;
      logic               x_outside;
      logic               y_outside;
      logic               w_zero;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] depth_gain;
      logic signed [31:0] depth_offset;
   } cfg_type;

   // One beat inside the divider: remainders, partial quotients and flags.
   typedef struct packed {
      logic               valid;
      logic               w_zero;
      logic [31:0]        w_mag;
      logic               x_neg;
      logic               y_neg;
      logic               z_neg;
      logic               x_ovf;
      logic               y_ovf;
      logic               z_ovf;
      logic [63:0]        x_rem;
      logic [63:0]        y_rem;
      logic [63:0]        z_rem;
      logic [X_QBITS-1:0] x_q;
      logic [X_QBITS-1:0] y_q;
      logic [Z_QBITS-1:0] z_q;
   } div_type;

endpackage

/* hw/rtl/vpts_front.sv */
// ----------------------------------------------------------------------------
// vpts_front
// Matrix products, magnitudes and divider setup for one vertex per cycle.
// ----------------------------------------------------------------------------
module vpts_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  vpts_pkg::req_type in_data,
   input  vpts_pkg::cfg_type cfg,
   output vpts_pkg::div_type div_out
);
   import vpts_pkg::*;

   logic    v1_ff, v2_ff, v3_ff;
   req_type req_ff;

   logic signed [63:0] px_ff, py_ff, p1_ff, p2_ff;
   logic signed [31:0] z2_ff;

   logic [63:0] xm_ff, ym_ff, zm_ff, xm_in, ym_in, zm_in;
   logic [31:0] wm_ff, wm_in;
   logic        xn_ff, yn_ff, zn_ff, wz_ff, xn_in, yn_in, zn_in, wz_in;
   logic signed [64:0] psum;

   div_type div_ff, div_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      req_ff <= in_data;
      px_ff  <= 64'(req_ff.vert_x) * 64'(cfg.scale_x);
      py_ff  <= 64'(req_ff.vert_y) * 64'(cfg.scale_y);
      p1_ff  <= 64'(req_ff.vert_z) * 64'(cfg.depth_gain);
      p2_ff  <= 64'(req_ff.vert_w) * 64'(cfg.depth_offset);
      z2_ff  <= req_ff.vert_z;
      xm_ff  <= xm_in;
      ym_ff  <= ym_in;
      zm_ff  <= zm_in;
      wm_ff  <= wm_in;
      xn_ff  <= xn_in;
      yn_ff  <= yn_in;
      zn_ff  <= zn_in;
      wz_ff  <= wz_in;
   end

   // The projected w is the negated z, so its sign is set when z is positive.
   always_comb begin
      psum  = 65'(p1_ff) + 65'(p2_ff);
      wz_in = (z2_ff == 32'sd0);
      wm_in = z2_ff[31] ? 32'(-33'(z2_ff)) : 32'(z2_ff);
      xn_in = px_ff[63] ^ (!z2_ff[31] && !wz_in);
      yn_in = py_ff[63] ^ (!z2_ff[31] && !wz_in);
      zn_in = psum[64] ^ (!z2_ff[31] && !wz_in);
      xm_in = px_ff[63] ? 64'(-px_ff) : 64'(px_ff);
      ym_in = py_ff[63] ? 64'(-py_ff) : 64'(py_ff);
      zm_in = psum[64] ? 64'(-psum) : psum[63:0];
   end

   // A quotient that cannot fit the lane is caught here and the lane is forced later.
   always_comb begin
      div_in       = '0;
      div_in.valid = v3_ff;
      div_in.w_zero = wz_ff;
      div_in.w_mag = wm_ff;
      div_in.x_neg = xn_ff;
      div_in.y_neg = yn_ff;
      div_in.z_neg = zn_ff;
      div_in.x_ovf = (xm_ff >= (64'(wm_ff) << X_QBITS));
      div_in.y_ovf = (ym_ff >= (64'(wm_ff) << X_QBITS));
      div_in.z_ovf = (zm_ff >= (64'(wm_ff) << Z_QBITS));
      div_in.x_rem = xm_ff;
      div_in.y_rem = ym_ff;
      div_in.z_rem = zm_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else begin
         div_ff <= div_in;
      end
   end

   assign div_out = div_ff;

endmodule

/* hw/rtl/vpts_divider.sv */
// ----------------------------------------------------------------------------
// vpts_divider
// Pipelined restoring divider, one quotient bit per stage for three lanes.
// ----------------------------------------------------------------------------
module vpts_divider (
   input  logic              clock,
   input  logic              reset,
   input  vpts_pkg::div_type div_in,
   output vpts_pkg::div_type div_out
);
   import vpts_pkg::*;

   div_type stage_ff [1:Z_QBITS];

   for (genvar k = Z_QBITS - 1; k >= 0; k--) begin : g_step
      localparam int I = Z_QBITS - 1 - k;
      div_type     cur;
      div_type     nxt;
      logic [63:0] dsub;

      if (I == 0) begin : g_first
         assign cur = div_in;
      end else begin : g_rest
         assign cur = stage_ff[I];
      end

      assign dsub = 64'(cur.w_mag) << k;

      // The x and y lanes only need their low quotient bits; above those
      // the overflow check already proved each bit is zero.
      always_comb begin
         nxt = cur;
         if (cur.z_rem >= dsub) begin
            nxt.z_rem = cur.z_rem - dsub;
            nxt.z_q   = {cur.z_q[Z_QBITS-2:0], 1'b1};
         end else begin
            nxt.z_q   = {cur.z_q[Z_QBITS-2:0], 1'b0};
         end
         if (k < X_QBITS) begin
            if (cur.x_rem >= dsub) begin
               nxt.x_rem = cur.x_rem - dsub;
               nxt.x_q   = {cur.x_q[X_QBITS-2:0], 1'b1};
            end else begin
               nxt.x_q   = {cur.x_q[X_QBITS-2:0], 1'b0};
            end
            if (cur.y_rem >= dsub) begin
               nxt.y_rem = cur.y_rem - dsub;
               nxt.y_q   = {cur.y_q[X_QBITS-2:0], 1'b1};
            end else begin
               nxt.y_q   = {cur.y_q[X_QBITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[I+1].valid <= 1'b0;
         end else begin
            stage_ff[I+1] <= nxt;
         end
      end
   end

   assign div_out = stage_ff[Z_QBITS];

endmodule

/* hw/rtl/vpts_map.sv */
// ----------------------------------------------------------------------------
// vpts_map
// Viewport mapping, clip flags and depth saturation into the result register.
// ----------------------------------------------------------------------------
module vpts_map (
   input  logic              clock,
   input  logic              reset,
   input  vpts_pkg::div_type div_in,
   output logic              rsp_valid,
   output vpts_pkg::rsp_type rsp_data
);
   import vpts_pkg::*;

   logic    valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic [31:0] xbase, ybase, xoff, yoff, xsum, ysum;
   logic        xo, yo, dneg;

   always_comb begin
      xbase = 32'(HALF_W) << 16;
      ybase = 32'(HALF_H) << 16;
      xoff  = 32'(div_in.x_q) * 32'(HALF_W);
      yoff  = 32'(div_in.y_q) * 32'(HALF_H);
      xsum  = div_in.x_neg ? xbase - xoff : xbase + xoff;
      ysum  = div_in.y_neg ? ybase - yoff : ybase + yoff;
      xo    = div_in.x_ovf || (div_in.x_q > ONE_Q16);
      yo    = div_in.y_ovf || (div_in.y_q > ONE_Q16);
      dneg  = div_in.z_neg;

      rsp_in           = '0;
      rsp_in.x_outside = xo;
      rsp_in.y_outside = yo;
      rsp_in.screen_x  = xo ? '0 : xsum[16 +: SX_BITS];
      rsp_in.screen_y  = yo ? '0 : ysum[16 +: SY_BITS];
      if (dneg) begin
         if (div_in.z_ovf || div_in.z_q > 32'h8000_0000) begin
            rsp_in.depth_ndc = 32'sh8000_0000;
         end else begin
            rsp_in.depth_ndc = 32'(-div_in.z_q);
         end
      end else begin
         if (div_in.z_ovf || div_in.z_q > 32'h7FFF_FFFF) begin
            rsp_in.depth_ndc = 32'sh7FFF_FFFF;
         end else begin
            rsp_in.depth_ndc = div_in.z_q;
         end
      end
      if (div_in.w_zero) begin
         rsp_in        = '0;
         rsp_in.w_zero = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= div_in.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/vertex_perspective_to_screen.sv */
// ----------------------------------------------------------------------------
// vertex_perspective_to_screen
// Perspective projection and viewport mapping of homogeneous vertices.
// ----------------------------------------------------------------------------
// A vertex is taken in every cycle that start is high; busy never rises.
// Each result appears on rsp_data with rsp_valid high for one cycle, in input
// order. A vertex passes through the input, product, magnitude and setup
// registers, the divider, which resolves one quotient bit per stage over 32
// stages, and the output register. Results cannot be held off, so the
// receiver must take every beat as it comes.
module vertex_perspective_to_screen (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  vpts_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output vpts_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [vpts_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0]                       csr_wdata
);
   import vpts_pkg::*;

   cfg_type cfg_ff;
   div_type front_div, div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_x      <= 32'sh0001_0000;
         cfg_ff.scale_y      <= 32'sh0001_0000;
         cfg_ff.depth_gain   <= 32'shFFFF_0000;
         cfg_ff.depth_offset <= 32'shFFFE_0000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCALE_X:      cfg_ff.scale_x      <= csr_wdata;
            CSR_SCALE_Y:      cfg_ff.scale_y      <= csr_wdata;
            CSR_DEPTH_GAIN:   cfg_ff.depth_gain   <= csr_wdata;
            CSR_DEPTH_OFFSET: cfg_ff.depth_offset <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   vpts_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_valid(start && !busy),
      .in_data (req_data),
      .cfg     (cfg_ff),
      .div_out (front_div)
   );

   vpts_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .div_in (front_div),
      .div_out(div_done)
   );

   vpts_map u_map (
      .clock    (clock),
      .reset    (reset),
      .div_in   (div_done),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result beat without a matching input beat");

   a_wzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.w_zero) |->
         (rsp_data.screen_x == '0 && rsp_data.screen_y == '0 &&
          rsp_data.depth_ndc == '0 && !rsp_data.x_outside && !rsp_data.y_outside))
      else $error("zero w result carries nonzero fields");

   a_xclip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.x_outside) |-> (rsp_data.screen_x == '0))
      else $error("clipped x has nonzero pixel");

   a_yclip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.y_outside) |-> (rsp_data.screen_y == '0))
      else $error("clipped y has nonzero pixel");
`endif

endmodule
